// ===== design/shamh_pkg.sv =====
// Shared types, constants and helper functions of the SHA-256 message hasher.
`timescale 1ns / 1ps
`default_nettype none

package shamh_pkg;

  typedef logic [0:7][31:0] hash_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_OUT
  } shamh_state_e;

  typedef struct packed {
    logic        shift_byte;
    logic [7:0]  byte_val;
    logic        sched_shift;
    logic        load_v;
    logic        round_en;
    logic        fold;
    logic        init_h;
    logic [5:0]  rnd;
  } shamh_ctl_t;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [7:0] PAD_ZERO      = 8'h00;
  localparam logic [5:0] LEN_POS       = 6'd56;
  localparam logic [5:0] LAST_POS      = 6'd63;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [1:0] LAST_WORD_IDX = 2'd3;

  localparam hash_t INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ===== design/shamh_sched.sv =====
// Block buffer and message schedule window: bytes shift in, schedule words shift out.
`timescale 1ns / 1ps
`default_nettype none

module shamh_sched (
  input  logic                 clk_i,
  input  shamh_pkg::shamh_ctl_t ctl_i,
  output logic [31:0]          w_o
);
  import shamh_pkg::*;

  // Slot j of the window sits at bits [511-32*j -: 32]; slot 0 is the current word.
  logic [511:0] win_q, win_d;
  logic [31:0]  w_next;

  assign w_next = win_q[511:480] + ssig0(win_q[479:448]) + win_q[223:192]
                + ssig1(win_q[63:32]);

  always_comb begin
    win_d = win_q;
    if (ctl_i.shift_byte) begin
      win_d = {win_q[503:0], ctl_i.byte_val};
    end else if (ctl_i.sched_shift) begin
      win_d = {win_q[479:0], w_next};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_o = win_q[511:480];

endmodule

`default_nettype wire

// ===== design/shamh_core.sv =====
// Round unit: working variables, one SHA-256 round per cycle, and the chaining words.
`timescale 1ns / 1ps
`default_nettype none

module shamh_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  shamh_pkg::shamh_ctl_t ctl_i,
  input  logic [31:0]           w_i,
  input  logic [1:0]            word_idx_i,
  output logic [63:0]           digest_o
);
  import shamh_pkg::*;

  hash_t       h_q, h_d;
  hash_t       v_q, v_d;
  logic [31:0] t1, t2, ch, maj;

  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[ctl_i.rnd] + w_i;
  assign t2  = bsig0(v_q[0]) + maj;

  always_comb begin
    v_d = v_q;
    if (ctl_i.load_v) begin
      v_d = h_q;
    end else if (ctl_i.round_en) begin
      v_d = {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
    end
  end

  always_comb begin
    h_d = h_q;
    if (ctl_i.init_h) begin
      h_d = INIT_H;
    end else if (ctl_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        h_d[i] = h_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= INIT_H;
    end else begin
      h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign digest_o = {h_q[{word_idx_i, 1'b0}], h_q[{word_idx_i, 1'b1}]};

endmodule

`default_nettype wire

// ===== design/shamh_ctrl.sv =====
// Sequencer: byte intake, round counting, byte-serial padding and digest word output.
`timescale 1ns / 1ps
`default_nettype none

module shamh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_present_i,
  input  logic                  in_end_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            word_idx_o,
  output logic                  last_word_o,
  output shamh_pkg::shamh_ctl_t ctl_o
);
  import shamh_pkg::*;

  shamh_state_e state_q, state_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [5:0]   pos_q, pos_d;
  logic [60:0]  cnt_q, cnt_d;
  logic [1:0]   widx_q, widx_d;
  logic         fin_q, fin_d;
  logic         pad_q, pad_d;
  logic         mark_q, mark_d;
  logic         lenb_q, lenb_d;
  logic [63:0]  bit_len;
  logic [63:0]  len_shifted;
  logic [7:0]   pad_byte;

  // Length bytes go out most significant first at positions 56 to 63.
  assign bit_len     = {cnt_q, 3'b000};
  assign len_shifted = bit_len >> {~pos_q[2:0], 3'b000};

  always_comb begin
    if (!mark_q) begin
      pad_byte = PAD_MARK;
    end else if (lenb_q && (pos_q >= LEN_POS)) begin
      pad_byte = len_shifted[7:0];
    end else begin
      pad_byte = PAD_ZERO;
    end
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    widx_d  = widx_q;
    fin_d   = fin_q;
    pad_d   = pad_q;
    mark_d  = mark_q;
    lenb_d  = lenb_q;
    ctl_o             = '0;
    ctl_o.byte_val    = in_byte_i;
    ctl_o.rnd         = rnd_q;
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          fin_d  = in_end_i;
          pad_d  = 1'b0;
          mark_d = 1'b0;
          lenb_d = 1'b0;
          if (in_present_i) begin
            ctl_o.shift_byte = 1'b1;
            pos_d = pos_q + 6'd1;
            cnt_d = cnt_q + 61'd1;
            if (pos_q == LAST_POS) begin
              ctl_o.load_v = 1'b1;
              rnd_d   = '0;
              state_d = S_ROUND;
            end else if (in_end_i) begin
              pad_d   = 1'b1;
              state_d = S_PAD;
            end
          end else if (in_end_i) begin
            pad_d   = 1'b1;
            state_d = S_PAD;
          end
        end
      end

      S_ROUND: begin
        ctl_o.round_en    = 1'b1;
        ctl_o.sched_shift = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = S_FOLD;
        end
      end

      S_FOLD: begin
        ctl_o.fold = 1'b1;
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (!pad_q) begin
          pad_d   = 1'b1;
          state_d = S_PAD;
        end else if (lenb_q) begin
          widx_d  = '0;
          state_d = S_OUT;
        end else begin
          // The marker did not leave room for the length: it goes in a second block.
          lenb_d  = 1'b1;
          state_d = S_PAD;
        end
      end

      S_PAD: begin
        ctl_o.shift_byte = 1'b1;
        ctl_o.byte_val   = pad_byte;
        pos_d = pos_q + 6'd1;
        if (!mark_q) begin
          mark_d = 1'b1;
          if (pos_q < LEN_POS) begin
            lenb_d = 1'b1;
          end
        end
        if (pos_q == LAST_POS) begin
          ctl_o.load_v = 1'b1;
          rnd_d   = '0;
          state_d = S_ROUND;
        end
      end

      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          widx_d = widx_q + 2'd1;
          if (widx_q == LAST_WORD_IDX) begin
            ctl_o.init_h = 1'b1;
            cnt_d   = '0;
            fin_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      widx_q  <= '0;
      fin_q   <= 1'b0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenb_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      widx_q  <= widx_d;
      fin_q   <= fin_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      lenb_q  <= lenb_d;
    end
  end

  assign word_idx_o  = widx_q;
  assign last_word_o = (widx_q == LAST_WORD_IDX);

  a_round_starts_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && $past(state_q) != S_ROUND) |-> rnd_q == '0)
    else $error("compression started with a nonzero round count");

  a_round_on_full_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> pos_q == '0)
    else $error("compression running on a partly filled block");

  a_out_after_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (lenb_q && mark_q && pos_q == '0))
    else $error("digest output before the length block was compressed");

  a_count_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (cnt_q == '0 && state_q == S_IDLE))
    else $error("message count not cleared after the last digest word");

endmodule

`default_nettype wire

// ===== design/sha256_message_hasher_unit.sv =====
// Top level of the SHA-256 message hasher: byte stream in, digest words out.
//
// The slave stream takes one message byte per word: tdata carries the byte, tuser
// says whether a byte is present and tlast ends the message. A word with tlast and
// no byte finishes the message with the tail held so far.
// A byte that does not complete a 64-byte block is taken without a stall. A byte that
// completes a block starts a compression: the rounds on the shared round unit, then
// the fold of the result into the chaining words, keep tready low until both are done.
// At the end of a message the padding (marker, zero fill, 64-bit bit length) is
// shifted into the block buffer one byte per cycle, with a compression after each
// padded block; the length takes a second block when the tail leaves no room for it.
// The digest then leaves on the master stream as four 64-bit big-endian words, tuser
// giving the word index and tlast marking the fourth.
// tready stays low during every compression and, once a message has ended, until the
// last digest word is taken, so a stalled receiver simply holds the block in its
// output state. Reset loads the initial hash values and clears the byte count; after
// the fourth word the block returns to that state for the next message.
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] digest_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast
);
  import shamh_pkg::*;

  shamh_ctl_t  ctl;
  logic [31:0] sched_w;
  logic [1:0]  word_idx;

  shamh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_present_i (s_axis_tuser),
    .in_end_i     (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .word_idx_o   (word_idx),
    .last_word_o  (m_axis_tlast),
    .ctl_o        (ctl)
  );

  shamh_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .w_o   (sched_w)
  );

  shamh_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .w_i        (sched_w),
    .word_idx_i (word_idx),
    .digest_o   (m_axis_tdata)
  );

  assign m_axis_tuser = word_idx;

endmodule

`default_nettype wire
